>>> rtl/ack_retry_table_assert.svh
// Assertion macros shared by the ack retry table RTL.
`ifndef ACK_RETRY_TABLE_ASSERT_SVH
`define ACK_RETRY_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ART_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ART_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/art_pkg.sv
// Types and constants shared by the ack retry table modules.
`default_nettype none

package art_pkg;

  localparam int KEY_W  = 32;
  localparam int ATT_W  = 4;
  localparam int SLOT_W = 3;
  localparam int STAT_W = 3;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_UPSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POLL    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_OUTCOME = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_QUEUED    = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_PRESENTED = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_NONE      = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_SENT      = 3'd4;
  localparam logic [STAT_W-1:0] STATUS_RETRY     = 3'd5;
  localparam logic [STAT_W-1:0] STATUS_DROPPED   = 3'd6;

  localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RESET = 4'd3;
  localparam logic [ATT_W-1:0] ATT_SATURATE       = 4'd15;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             kind;
    logic [ATT_W-1:0] att;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  entry_id;
    logic              entry_kind;
    slot_t             slot;
    logic [ATT_W-1:0]  attempts_now;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } store_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/art_if.sv
// Valid/ready channel interfaces for ack retry table requests and responses.
`default_nettype none

interface art_req_if;
  logic                          valid;
  logic                          ready;
  logic [art_pkg::FUNC_W-1:0]    func;
  logic [art_pkg::KEY_W-1:0]     id_key;
  logic                          ack_kind;
  logic                          publish_ok;

  modport source (output valid, func, id_key, ack_kind, publish_ok, input ready);
  modport sink (input valid, func, id_key, ack_kind, publish_ok, output ready);
endinterface

interface art_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [art_pkg::STAT_W-1:0]    status;
  logic [art_pkg::KEY_W-1:0]     entry_id;
  logic                          entry_kind;
  logic [art_pkg::SLOT_W-1:0]    slot;
  logic [art_pkg::ATT_W-1:0]     attempts_now;

  modport source (output valid, status, entry_id, entry_kind, slot, attempts_now,
                  input ready);
  modport sink (input valid, status, entry_id, entry_kind, slot, attempts_now,
                output ready);
endinterface

`default_nettype wire

>>> rtl/art_store.sv
// Entry memory with registered read and per-slot valid flags.
`default_nettype none

module art_store #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire art_pkg::store_ctrl_t ctrl,
  input  wire logic [IDX_W-1:0]     rd_addr,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire art_pkg::entry_t      wr_data,
  output art_pkg::entry_t           rd_data,
  output logic [DEPTH-1:0]          valid_bits
);

  art_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (ctrl.set_valid) begin
      valid_bits[wr_addr] <= 1'b1;
    end else if (ctrl.clr_valid) begin
      valid_bits[wr_addr] <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/art_seq.sv
// Slot-walking sequencer with the shared key comparator and attempt update.
`default_nettype none

module art_seq #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  art_req_if.sink                       req,
  input  wire logic [art_pkg::ATT_W-1:0] max_attempts,
  input  wire logic [DEPTH-1:0]         valid_bits,
  input  wire art_pkg::entry_t          rd_data,
  output art_pkg::store_ctrl_t          ctrl,
  output logic [IDX_W-1:0]              rd_addr,
  output logic [IDX_W-1:0]              wr_addr,
  output art_pkg::entry_t               wr_data,
  output art_pkg::result_t              res,
  output logic                          res_valid,
  input  wire logic                     res_ready
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_FIN, S_OUT} state_t;

  state_t                       state;
  logic [IDX_W-1:0]             idx;
  logic [IDX_W-1:0]             free_idx;
  logic                         free_found;
  logic                         hit;
  logic [art_pkg::FUNC_W-1:0]   func_q;
  logic [art_pkg::KEY_W-1:0]    key_q;
  logic                         kind_q;
  logic                         ok_q;
  art_pkg::result_t             res_next;
  logic [art_pkg::ATT_W-1:0]    att_inc;
  logic                         drop;
  logic                         last;

  assign last      = (idx == IDX_W'(DEPTH - 1));
  assign att_inc   = (rd_data.att == art_pkg::ATT_SATURATE) ? rd_data.att
                                                            : rd_data.att + 1'b1;
  assign drop      = (att_inc >= max_attempts);
  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign rd_addr   = idx;

  always_comb begin
    ctrl         = '0;
    wr_addr      = idx;
    wr_data.key  = key_q;
    wr_data.kind = kind_q;
    wr_data.att  = '0;
    res_next              = '0;
    res_next.status       = art_pkg::STATUS_NONE;
    if (state == S_RD) begin
      ctrl.rd_en = valid_bits[idx];
    end
    if (state == S_FIN) begin
      if (func_q == art_pkg::FUNC_UPSERT) begin
        res_next.entry_id   = key_q;
        res_next.entry_kind = kind_q;
        if (hit) begin
          ctrl.wr_en      = 1'b1;
          res_next.status = art_pkg::STATUS_QUEUED;
          res_next.slot   = art_pkg::slot_t'(idx);
        end else if (free_found) begin
          ctrl.wr_en      = 1'b1;
          ctrl.set_valid  = 1'b1;
          wr_addr         = free_idx;
          res_next.status = art_pkg::STATUS_QUEUED;
          res_next.slot   = art_pkg::slot_t'(free_idx);
        end else begin
          res_next.status = art_pkg::STATUS_FULL;
        end
      end else if (hit) begin
        res_next.entry_id     = rd_data.key;
        res_next.entry_kind   = rd_data.kind;
        res_next.slot         = art_pkg::slot_t'(idx);
        res_next.attempts_now = rd_data.att;
        wr_data.key           = rd_data.key;
        wr_data.kind          = rd_data.kind;
        wr_data.att           = att_inc;
        if (func_q == art_pkg::FUNC_POLL) begin
          res_next.status = art_pkg::STATUS_PRESENTED;
        end else if (ok_q) begin
          ctrl.clr_valid  = 1'b1;
          res_next.status = art_pkg::STATUS_SENT;
        end else begin
          ctrl.wr_en            = 1'b1;
          ctrl.clr_valid        = drop;
          res_next.attempts_now = att_inc;
          res_next.status = drop ? art_pkg::STATUS_DROPPED : art_pkg::STATUS_RETRY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      free_idx   <= '0;
      free_found <= 1'b0;
      hit        <= 1'b0;
      func_q     <= art_pkg::FUNC_UNUSED;
      key_q      <= '0;
      kind_q     <= 1'b0;
      ok_q       <= 1'b0;
      res        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            func_q     <= req.func;
            key_q      <= req.id_key;
            kind_q     <= req.ack_kind;
            ok_q       <= req.publish_ok;
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= (req.func == art_pkg::FUNC_UNUSED) ? S_FIN : S_RD;
          end
        end
        S_RD: begin
          if (valid_bits[idx]) begin
            state <= S_CHK;
          end else begin
            if (func_q == art_pkg::FUNC_UPSERT && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= idx;
            end
            if (last) begin
              state <= S_FIN;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_CHK: begin
          if (func_q != art_pkg::FUNC_UPSERT || rd_data.key == key_q) begin
            hit   <= 1'b1;
            state <= S_FIN;
          end else if (last) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          res   <= res_next;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ack_retry_table.sv
// Top level of the ack retry table: configuration, sequencer, store and response register.
//
//   channel  | dir | handshake          | payload
//   req      | in  | valid/ready        | func, id_key, ack_kind, publish_ok
//   rsp      | out | valid/ready        | status, entry_id, entry_kind, slot, attempts_now
//   cfg      | in  | cfg_write_en       | cfg_write_data = max_attempts
//
// After its transfer an item's result is registered in S_FIN and held in S_OUT until the
// response register takes it; the next request can be taken in the cycle after that.
// The walk visits a free slot in S_RD and an occupied slot in S_RD then S_CHK, whose entry
// comes from the single read port of the entry memory into the shared key comparator.
// Reset clears every valid flag and sets max_attempts to 3; no clearing pass is needed.
// A new request is taken while a response waits in the output register; a stalled
// response holds the sequencer only when the next one is ready to leave.
`default_nettype none

`include "ack_retry_table_assert.svh"

module ack_retry_table #(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  art_req_if.sink                        req,
  art_rsp_if.source                      rsp,
  input  wire logic                      cfg_write_en,
  input  wire logic [art_pkg::ATT_W-1:0] cfg_write_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [art_pkg::ATT_W-1:0] max_attempts;
  art_pkg::store_ctrl_t      ctrl;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          wr_addr;
  art_pkg::entry_t           wr_data;
  art_pkg::entry_t           rd_data;
  logic [TABLE_DEPTH-1:0]    valid_bits;
  art_pkg::result_t          res;
  logic                      res_valid;
  logic                      res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts <= art_pkg::MAX_ATTEMPTS_RESET;
    end else if (cfg_write_en) begin
      max_attempts <= cfg_write_data;
    end
  end

  art_seq #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .max_attempts (max_attempts),
    .valid_bits   (valid_bits),
    .rd_data      (rd_data),
    .ctrl         (ctrl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res          (res),
    .res_valid    (res_valid),
    .res_ready    (res_ready)
  );

  art_store #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data),
    .valid_bits (valid_bits)
  );

  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.status       <= res.status;
      rsp.entry_id     <= res.entry_id;
      rsp.entry_kind   <= res.entry_kind;
      rsp.slot         <= res.slot;
      rsp.attempts_now <= res.attempts_now;
    end
  end

  `ART_ASSERT_NEXT(a_busy_after_transfer, clk, rst,
                   req.valid && req.ready, !req.ready,
                   "request taken while busy")
  `ART_ASSERT_NEXT(a_result_reaches_port, clk, rst,
                   res_valid && res_ready, rsp.valid,
                   "result lost before the response register")
  `ART_ASSERT_NOW(a_none_is_empty, clk, rst,
                  rsp.valid && rsp.status == art_pkg::STATUS_NONE,
                  rsp.entry_id == '0 && rsp.slot == '0 && rsp.attempts_now == '0,
                  "none pending with nonzero fields")
  `ART_ASSERT_NOW(a_full_has_no_slot, clk, rst,
                  rsp.valid && rsp.status == art_pkg::STATUS_FULL,
                  rsp.slot == '0 && rsp.attempts_now == '0,
                  "table full with slot or attempts set")

endmodule

`default_nettype wire
